// ===== rtl/core/mandelbrot_escape_count_macros.svh =====
// Assertion macros shared by the escape-count RTL.
`ifndef MANDELBROT_ESCAPE_COUNT_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mec_pkg.sv =====
// Shared constants, types and helpers for the escape-count block.
package mec_pkg;

   localparam int Q_W        = 32;
   localparam int FRAC_BITS  = 27;
   localparam int PROD_W     = 2 * Q_W;
   localparam int SUM_W      = Q_W + 6;
   localparam int COUNT_W    = 9;
   localparam int MAX_LIMIT  = 256;
   localparam int LIMIT_RESET = 256;

   localparam logic [PROD_W-1:0] ESCAPE_SQ_THRESHOLD = PROD_W'(4) << (2 * FRAC_BITS);
   localparam logic [COUNT_W-1:0] MAX_LIMIT_CNT = COUNT_W'(MAX_LIMIT);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ITERATION_LIMIT = 1'b0;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic start;
      logic mul;
      logic step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic escape;
      logic last;
   } status_type;

   // Clamp a widened sum back to the signed Q5.27 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v[SUM_W-1:Q_W-1] == {(SUM_W-Q_W+1){v[SUM_W-1]}}) begin
         r = v[Q_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/mec_datapath.sv =====
// Datapath: z registers, product stage, update with saturation, step counter.
`include "mandelbrot_escape_count_macros.svh"

module mec_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mec_pkg::cmd_type                      cmd,
   output mec_pkg::status_type                   status,
   input  logic signed [mec_pkg::Q_W-1:0]        c_real,
   input  logic signed [mec_pkg::Q_W-1:0]        c_imag,
   input  logic [mec_pkg::COUNT_W-1:0]           cfg_limit,
   output logic [mec_pkg::COUNT_W-1:0]           escape_count
);

   logic signed [mec_pkg::Q_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [mec_pkg::Q_W-1:0]    cr_ff, ci_ff;
   logic signed [mec_pkg::PROD_W-1:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [mec_pkg::COUNT_W-1:0]       n_ff, n_in, lim_ff, lim_in, res_ff;
   logic [mec_pkg::COUNT_W-1:0]       eff_limit;
   logic [mec_pkg::PROD_W-1:0]        mag;
   logic signed [mec_pkg::SUM_W-1:0]  nr_sum, ni_sum;

   assign eff_limit = (cfg_limit > mec_pkg::MAX_LIMIT_CNT) ? mec_pkg::MAX_LIMIT_CNT : cfg_limit;

   assign rr_in = zr_ff * zr_ff;
   assign ii_in = zi_ff * zi_ff;
   assign ri_in = zr_ff * zi_ff;

   // Both squares are non-negative and at most 2^62, so the sum fits in 64 unsigned bits.
   assign mag    = rr_ff + ii_ff;
   assign nr_sum = mec_pkg::SUM_W'((rr_ff - ii_ff) >>> mec_pkg::FRAC_BITS)
                   + mec_pkg::SUM_W'(cr_ff);
   assign ni_sum = mec_pkg::SUM_W'(ri_ff >>> (mec_pkg::FRAC_BITS - 1))
                   + mec_pkg::SUM_W'(ci_ff);

   always_comb begin
      zr_in  = zr_ff;
      zi_in  = zi_ff;
      n_in   = n_ff;
      lim_in = lim_ff;
      if (cmd.start) begin
         zr_in  = '0;
         zi_in  = '0;
         n_in   = '0;
         lim_in = eff_limit;
      end else if (cmd.step) begin
         zr_in = mec_pkg::sat_q(nr_sum);
         zi_in = mec_pkg::sat_q(ni_sum);
         n_in  = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zr_ff  <= '0;
         zi_ff  <= '0;
         n_ff   <= '0;
         lim_ff <= '0;
      end else begin
         zr_ff  <= zr_in;
         zi_ff  <= zi_in;
         n_ff   <= n_in;
         lim_ff <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cr_ff <= c_real;
         ci_ff <= c_imag;
      end
      if (cmd.mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.load_rsp) begin
         res_ff <= n_ff;
      end
   end

   assign status.limit_zero = (eff_limit == '0);
   assign status.escape     = (mag > mec_pkg::ESCAPE_SQ_THRESHOLD);
   assign status.last       = ((n_ff + 1'b1) == lim_ff);
   assign escape_count      = res_ff;

   `MEC_ASSERT_NOW(a_count_within_limit, 1'b1, n_ff <= lim_ff, "step count passed limit")
   `MEC_ASSERT_NOW(a_no_step_on_escape, cmd.step, !status.escape, "step taken after escape")
   `MEC_ASSERT_NEXT(a_result_within_limit, cmd.load_rsp, res_ff <= lim_ff,
                    "result above limit")

endmodule

// ===== rtl/core/mec_ctrl.sv =====
// Controller: sequences start, multiply, check/update and result hand-off.
`include "mandelbrot_escape_count_macros.svh"

module mec_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mec_pkg::cmd_type    cmd,
   input  mec_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_CHK  = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = status.limit_zero ? ST_HOLD : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.step = !status.escape;
            state_in = (status.escape || status.last) ? ST_HOLD : ST_MUL;
         end
         ST_HOLD: begin
            // wait until the output register is free, then load the count
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `MEC_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready,
                    "new transfer taken while busy")
   `MEC_ASSERT_NOW(a_load_into_free_slot, cmd.load_rsp, !rsp_valid_ff || rsp_tready,
                   "result overwritten before transfer")
   `MEC_ASSERT_NOW(a_check_follows_mul, state_ff == ST_CHK, $past(state_ff) == ST_MUL,
                   "check without fresh products")

endmodule

// ===== rtl/core/mandelbrot_escape_count.sv =====
// Top level of the escape-count block: CSR port, controller and datapath.
//
// Usage:
//   req_* carries one point c per transfer: tdata[31:0] c_real, tdata[63:32]
//   c_imag, both signed Q5.27. rsp_* returns one escape_count per point in
//   tdata[8:0]. The csr_* port holds iteration_limit at byte address 0
//   (reset 256; only bits [8:0] are written; values above 256 act as 256).
//   Each iteration has two steps: ST_MUL forms the three 32x32 products
//   into registers, ST_CHK tests |z|^2 > 4 and writes back the saturated z.
//   The loop ends when z escapes or the limit is reached; a zero limit
//   skips it. The next point is taken the cycle after the result is
//   loaded, so points are iterated one at a time through the shared
//   multiplier set.
//   The finished count sits in an output register; while the receiver
//   stalls, a following point is taken and iterated, and its count waits
//   inside until the register has been transferred.
//   Reset (synchronous, active high) drops any point in flight, empties the
//   output register and returns the limit to 256. No clearing pass.
module mandelbrot_escape_count (
   input  logic                               clock,
   input  logic                               reset,
   // tdata fields from bit 0: c_real[31:0], c_imag[63:32]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mec_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tdata fields from bit 0: escape_count[8:0], zero fill [15:9]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mec_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mec_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mec_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mec_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   mec_pkg::cmd_type               cmd;
   mec_pkg::status_type            status;
   logic [mec_pkg::COUNT_W-1:0]    limit_ff, limit_in;
   logic [mec_pkg::COUNT_W-1:0]    escape_count;
   logic                           csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (csr_paddr[2] == mec_pkg::REG_ITERATION_LIMIT)) begin
         limit_in = csr_pwdata[mec_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mec_pkg::COUNT_W'(mec_pkg::LIMIT_RESET);
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == mec_pkg::REG_ITERATION_LIMIT)
                       ? mec_pkg::CSR_DATA_W'(limit_ff) : '0;

   mec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   mec_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .c_real       (req_tdata[mec_pkg::Q_W-1:0]),
      .c_imag       (req_tdata[2*mec_pkg::Q_W-1:mec_pkg::Q_W]),
      .cfg_limit    (limit_ff),
      .escape_count (escape_count)
   );

   assign rsp_tdata = mec_pkg::RSP_DATA_W'(escape_count);

endmodule
